// ----- rtl/core/small_set_store_macros.svh -----
// ---------------------------------------------------------------------------
// small_set_store assertion macros
// shared concurrent assertion forms for the set store modules
// ---------------------------------------------------------------------------
`ifndef SMALL_SET_STORE_MACROS_SVH
`define SMALL_SET_STORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("set store check failed");

// next-cycle implication, disabled during reset
`define SSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("set store check failed");

`endif

// ----- rtl/core/sss_pkg.sv -----
// ---------------------------------------------------------------------------
// sss_pkg
// shared sizes, operation codes and control types of the set store
// ---------------------------------------------------------------------------
package sss_pkg;

    // store size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // search and update the store
    } t_ctrl_cmd;

endpackage

// ----- rtl/core/small_set_store.sv -----
// ---------------------------------------------------------------------------
// small_set_store
// set of distinct 32-bit values in insertion order: add, remove, find
// ---------------------------------------------------------------------------
//  channel   | handshake          | fields
//  ----------+--------------------+-----------------------------------------
//  request   | start / busy       | i_op, i_value
//  result    | o_valid (strobe)   | o_success, o_position, o_full_res, o_count
//
//  an item is taken when start is high and busy low; busy is then high for
//  one cycle while all cells are compared and the store is updated.
//  the result strobes on o_valid the cycle after; busy is already low then,
//  so a new item can be taken in the cycle that the result strobes.
//  synchronous active-low reset empties the store; entry contents need none.
//  the receiver cannot stall: a result is valid for exactly one cycle.
// ---------------------------------------------------------------------------
module small_set_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sss_pkg::OP_W-1:0]          i_op,
    input  logic signed [sss_pkg::VAL_W-1:0]  i_value,
    output logic                              o_valid,
    output logic                              o_success,
    output logic [sss_pkg::POS_W-1:0]         o_position,
    output logic                              o_full_res,
    output logic [sss_pkg::COUNT_W-1:0]       o_count
);
    import sss_pkg::*;

    t_ctrl_cmd cmd;

    // controller
    sss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_valid (o_valid)
    );

    // datapath
    sss_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_op       (i_op),
        .i_value    (i_value),
        .o_success  (o_success),
        .o_position (o_position),
        .o_full_res (o_full_res),
        .o_count    (o_count)
    );

endmodule

// ----- rtl/core/sss_ctrl.sv -----
// ---------------------------------------------------------------------------
// sss_ctrl
// controller: accepts an item, runs the execute state, strobes the result
// ---------------------------------------------------------------------------
`include "small_set_store_macros.svh"

module sss_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output sss_pkg::t_ctrl_cmd o_cmd,
    output logic               o_valid
);
    import sss_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_valid;

    // command decode
    assign busy       = (r_state != S_IDLE);
    assign o_cmd.load = start && (r_state == S_IDLE);
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_valid    = r_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= o_cmd.exec;
        end
    end

    `SSS_ASSERT_NXT(a_exec_gives_valid, i_clk, i_rst_n, o_cmd.exec, r_valid)
    `SSS_ASSERT_IMP(a_valid_when_idle, i_clk, i_rst_n, r_valid, r_state == S_IDLE)
    `SSS_ASSERT_NXT(a_load_to_exec, i_clk, i_rst_n, o_cmd.load, r_state == S_EXEC && busy)

endmodule

// ----- rtl/core/sss_dp.sv -----
// ---------------------------------------------------------------------------
// sss_dp
// datapath: entry cells, parallel match, append and shift-down update
// ---------------------------------------------------------------------------
`include "small_set_store_macros.svh"

module sss_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sss_pkg::t_ctrl_cmd                i_cmd,
    input  logic [sss_pkg::OP_W-1:0]          i_op,
    input  logic signed [sss_pkg::VAL_W-1:0]  i_value,
    output logic                              o_success,
    output logic [sss_pkg::POS_W-1:0]         o_position,
    output logic                              o_full_res,
    output logic [sss_pkg::COUNT_W-1:0]       o_count
);
    import sss_pkg::*;

    // captured item
    logic [OP_W-1:0]         r_op;
    logic signed [VAL_W-1:0] r_value;

    // store
    logic signed [VAL_W-1:0] r_entry [CAPACITY];
    logic signed [VAL_W-1:0] n_entry [CAPACITY];
    logic [CAPACITY-1:0]     cell_we;
    logic [CNT_W-1:0]        r_held;
    logic [CNT_W-1:0]        n_held;

    // search
    logic [CAPACITY-1:0]     match;
    logic                    hit;
    logic [IDX_W-1:0]        slot;
    logic                    is_full;
    logic                    add_ok;
    logic                    rem_ok;
    logic                    dup_add;

    // result
    logic                    r_success;
    logic [POS_W-1:0]        r_position;
    logic                    r_full_res;
    logic [COUNT_W-1:0]      r_count;
    logic                    n_success;
    logic [POS_W-1:0]        n_position;
    logic                    n_full_res;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
    end

    // per-cell compare against the held entries
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            match[k] = (CNT_W'(k) < r_held) && (r_entry[k] == r_value);
        end
    end

    // values are distinct, so at most one match: or-encode its slot
    always_comb begin
        slot = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (match[k]) begin
                slot = slot | IDX_W'(k);
            end
        end
    end

    assign hit     = |match;
    assign is_full = (r_held == CNT_W'(CAPACITY));
    assign dup_add = i_cmd.exec && (r_op == OP_ADD) && hit;

    // operation decode
    always_comb begin
        n_held     = r_held;
        n_success  = 1'b0;
        n_position = '0;
        n_full_res = 1'b0;
        add_ok     = 1'b0;
        rem_ok     = 1'b0;
        unique case (r_op)
            OP_ADD: begin
                if (!hit && is_full) begin
                    n_full_res = 1'b1;
                end else if (!hit) begin
                    add_ok     = i_cmd.exec;
                    n_success  = 1'b1;
                    n_position = POS_W'(r_held);
                    n_held     = r_held + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    rem_ok     = i_cmd.exec;
                    n_success  = 1'b1;
                    n_position = POS_W'(slot);
                    n_held     = r_held - CNT_W'(1);
                end
            end
            OP_FIND: begin
                if (hit) begin
                    n_success  = 1'b1;
                    n_position = POS_W'(slot);
                end
            end
            default: begin
                n_held = r_held;
            end
        endcase
    end

    // cell write: append at the tail, or take the upper neighbor above the gap
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            cell_we[k] = 1'b0;
            n_entry[k] = r_entry[k];
            if (add_ok && (r_held == CNT_W'(k))) begin
                cell_we[k] = 1'b1;
                n_entry[k] = r_value;
            end else if (rem_ok && (IDX_W'(k) >= slot) && (k < CAPACITY - 1)) begin
                cell_we[k] = 1'b1;
                n_entry[k] = r_entry[(k + 1) % CAPACITY];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (cell_we[g]) begin
                r_entry[g] <= n_entry[g];
            end
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.exec) begin
            r_held <= n_held;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_success  <= n_success;
            r_position <= n_position;
            r_full_res <= n_full_res;
            r_count    <= COUNT_W'(n_held);
        end
    end

    assign o_success  = r_success;
    assign o_position = r_position;
    assign o_full_res = r_full_res;
    assign o_count    = r_count;

    `SSS_ASSERT_IMP(a_held_in_range, i_clk, i_rst_n, 1'b1, r_held <= CNT_W'(CAPACITY))
    `SSS_ASSERT_NXT(a_remove_shrinks, i_clk, i_rst_n, rem_ok, r_held == $past(r_held) - CNT_W'(1))
    `SSS_ASSERT_NXT(a_dup_add_keeps, i_clk, i_rst_n, dup_add, r_held == $past(r_held))
    `SSS_ASSERT_NXT(a_dup_add_fails, i_clk, i_rst_n, dup_add, !r_success && !r_full_res)

endmodule
